/* src/tsh_pkg.sv */
// tsh_pkg: shared types, constants and ones-complement helpers
// for the tcp syn header builder; no dependencies
package tsh_pkg;

    localparam int unsigned ADDR_SUM_W = 19;  // up to eight 16-bit terms
    localparam int unsigned HDR_SUM_W  = 21;  // all terms of the checksum

    localparam logic [15:0] WINDOW_RESET    = 16'd64240;
    localparam logic [15:0] OFFSET_SYN_WORD = 16'h5002;
    localparam logic [15:0] TCP_PROTO       = 16'd6;
    localparam logic [15:0] TCP_HDR_LEN     = 16'd20;

    // header word positions
    localparam logic [2:0] WORD_PORTS = 3'd0;
    localparam logic [2:0] WORD_SEQ   = 3'd1;
    localparam logic [2:0] WORD_ACK   = 3'd2;
    localparam logic [2:0] WORD_FLAGS = 3'd3;
    localparam logic [2:0] WORD_CSUM  = 3'd4;

    // register byte addresses
    localparam logic [2:0] ADDR_WINDOW = 3'd0;

    typedef struct packed {
        logic [ADDR_SUM_W-1:0] src_sum;
        logic [ADDR_SUM_W-1:0] dst_sum;
        logic [15:0]           sport;
        logic [15:0]           dport;
        logic [31:0]           seq_number;
    } addr_stage_t;

    typedef struct packed {
        logic [HDR_SUM_W-1:0] sum;
        logic [15:0]          sport;
        logic [15:0]          dport;
        logic [31:0]          seq_number;
        logic [15:0]          window;
    } sum_stage_t;

    typedef struct packed {
        logic [15:0] checksum;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] seq_number;
        logic [15:0] window;
    } hdr_item_t;

    function automatic logic [17:0] hsum32(input logic [31:0] v);
        logic [17:0] s;
        s = 18'(v[31:16]) + 18'(v[15:0]);
        return s;
    endfunction

    function automatic logic [17:0] hsum64(input logic [63:0] v);
        logic [17:0] s;
        s = 18'(v[63:48]) + 18'(v[47:32]) + 18'(v[31:16]) + 18'(v[15:0]);
        return s;
    endfunction

endpackage

/* src/tsh_sum.sv */
// tsh_sum: two pipeline stages that add up the pseudo-header and header
// halfwords; depends on tsh_pkg
module tsh_sum
    import tsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        is_ipv6,
    input  logic [63:0] src_addr_hi,
    input  logic [63:0] src_addr_lo,
    input  logic [63:0] dst_addr_hi,
    input  logic [63:0] dst_addr_lo,
    input  logic [15:0] sport,
    input  logic [15:0] dport,
    input  logic [31:0] seq_number,
    input  logic [15:0] window,
    output logic        out_valid,
    input  logic        out_ready,
    output sum_stage_t  out_item
);

    logic        s1_valid_reg;
    addr_stage_t s1_reg;
    addr_stage_t s1_next;
    logic        s1_ready;
    logic        s2_valid_reg;
    sum_stage_t  s2_reg;
    sum_stage_t  s2_next;
    logic        s2_ready;

    // stage 1: address halfwords
    always_comb
    begin
        s1_next.sport      = sport;
        s1_next.dport      = dport;
        s1_next.seq_number = seq_number;
        if (is_ipv6)
        begin
            s1_next.src_sum = ADDR_SUM_W'(hsum64(src_addr_hi)) + ADDR_SUM_W'(hsum64(src_addr_lo));
            s1_next.dst_sum = ADDR_SUM_W'(hsum64(dst_addr_hi)) + ADDR_SUM_W'(hsum64(dst_addr_lo));
        end
        else
        begin
            s1_next.src_sum = ADDR_SUM_W'(hsum32(src_addr_lo[31:0]));
            s1_next.dst_sum = ADDR_SUM_W'(hsum32(dst_addr_lo[31:0]));
        end
    end

    // stage 2: remaining header terms and constants
    always_comb
    begin
        s2_next.sport      = s1_reg.sport;
        s2_next.dport      = s1_reg.dport;
        s2_next.seq_number = s1_reg.seq_number;
        s2_next.window     = window;
        s2_next.sum        = HDR_SUM_W'(s1_reg.src_sum) + HDR_SUM_W'(s1_reg.dst_sum)
                           + HDR_SUM_W'(s1_reg.sport) + HDR_SUM_W'(s1_reg.dport)
                           + HDR_SUM_W'(s1_reg.seq_number[31:16])
                           + HDR_SUM_W'(s1_reg.seq_number[15:0])
                           + HDR_SUM_W'(TCP_PROTO) + HDR_SUM_W'(TCP_HDR_LEN)
                           + HDR_SUM_W'(OFFSET_SYN_WORD) + HDR_SUM_W'(window);
    end

    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_item  = s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
            s1_reg <= s1_next;
        if (s2_ready && s1_valid_reg)
            s2_reg <= s2_next;
    end

endmodule

/* src/tsh_fold.sv */
// tsh_fold: pipeline stage with end-around carry fold and inversion
// of the checksum; depends on tsh_pkg
module tsh_fold
    import tsh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  sum_stage_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output hdr_item_t  out_item
);

    logic        valid_reg;
    hdr_item_t   item_reg;
    hdr_item_t   item_next;
    logic [16:0] fold1;
    logic [15:0] fold2;

    always_comb
    begin
        fold1 = 17'(in_item.sum[15:0]) + 17'(in_item.sum[HDR_SUM_W-1:16]);
        // second carry cannot ripple out again
        fold2 = fold1[15:0] + 16'(fold1[16]);
        item_next.checksum   = ~fold2;
        item_next.sport      = in_item.sport;
        item_next.dport      = in_item.dport;
        item_next.seq_number = in_item.seq_number;
        item_next.window     = in_item.window;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

endmodule

/* src/tsh_serializer.sv */
// tsh_serializer: holds one finished header and sends it as five words;
// depends on tsh_pkg
module tsh_serializer
    import tsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  hdr_item_t   in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] header_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    logic        busy_reg;
    logic [2:0]  idx_reg;
    hdr_item_t   item_reg;
    logic        word_taken;
    logic        at_last;

    assign at_last    = (idx_reg == WORD_CSUM);
    assign word_taken = busy_reg && !out_stall;
    assign in_ready   = !busy_reg || (word_taken && at_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= WORD_PORTS;
        end
        else if (in_ready)
        begin
            busy_reg <= in_valid;
            idx_reg  <= WORD_PORTS;
        end
        else if (word_taken)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= in_item;
    end

    always_comb
    begin
        unique case (idx_reg)
            WORD_PORTS: header_word = {item_reg.sport, item_reg.dport};
            WORD_SEQ:   header_word = item_reg.seq_number;
            WORD_ACK:   header_word = 32'd0;
            WORD_FLAGS: header_word = {OFFSET_SYN_WORD, item_reg.window};
            WORD_CSUM:  header_word = {item_reg.checksum, 16'd0};
            default:    header_word = 32'd0;
        endcase
    end

    assign out_valid  = busy_reg;
    assign word_index = idx_reg;
    assign last_word  = at_last;

endmodule

/* src/tcp_syn_header_builder.sv */
// tcp_syn_header_builder: top level with register port and pipeline
// depends on tsh_pkg, tsh_sum, tsh_fold, tsh_serializer
//
// Builds a 20-byte option-free TCP SYN header for each probe and sends it
// as five 32-bit big-endian words, index 0 to 4, last_word high on word 4.
// The checksum covers the IPv4 or IPv6 pseudo-header (protocol 6, length
// 20) and the header, with every carry added back end-around. A probe
// passes three pipeline stages (address sums, header sum, carry fold) and
// lands in a word serializer, which registers it before its first word
// is on the output. The serializer takes a new probe only once the last
// word of the previous header is taken, and loads the next header in the
// same cycle as that last word. The window register (byte address 0)
// resets to 64240; the user must write it over the APB-style port only
// while the block is idle, which the block itself does not enforce.
module tcp_syn_header_builder
    import tsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // probe input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        is_ipv6,
    input  logic [63:0] src_addr_hi,
    input  logic [63:0] src_addr_lo,
    input  logic [63:0] dst_addr_hi,
    input  logic [63:0] dst_addr_lo,
    input  logic [15:0] sport,
    input  logic [15:0] dport,
    input  logic [31:0] seq_number,
    // header word output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] header_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    logic [15:0] window_reg;
    logic        hit_window;
    logic        sum_ready;
    logic        sum_valid;
    sum_stage_t  sum_item;
    logic        fold_ready;
    logic        fold_valid;
    hdr_item_t   fold_item;
    logic        ser_ready;

    // register port, no wait states; only paddr[2] is decoded, so addresses 0 to 3 all select the window
    assign pready     = 1'b1;
    assign hit_window = (paddr[2] == ADDR_WINDOW[2]);
    assign prdata     = hit_window ? {16'd0, window_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= WINDOW_RESET;
        else if (psel && penable && pwrite && hit_window)
            window_reg <= pwdata[15:0];
    end

    // stages 1 and 2: halfword sums
    tsh_sum u_sum (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (sum_ready),
        .is_ipv6     (is_ipv6),
        .src_addr_hi (src_addr_hi),
        .src_addr_lo (src_addr_lo),
        .dst_addr_hi (dst_addr_hi),
        .dst_addr_lo (dst_addr_lo),
        .sport       (sport),
        .dport       (dport),
        .seq_number  (seq_number),
        .window      (window_reg),
        .out_valid   (sum_valid),
        .out_ready   (fold_ready),
        .out_item    (sum_item)
    );

    assign in_stall = !sum_ready;

    // stage 3: fold and invert
    tsh_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (fold_ready),
        .in_item   (sum_item),
        .out_valid (fold_valid),
        .out_ready (ser_ready),
        .out_item  (fold_item)
    );

    // word serializer doubles as the output register
    tsh_serializer u_ser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (fold_valid),
        .in_ready    (ser_ready),
        .in_item     (fold_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .header_word (header_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule
